// ----- design/hcbp_pkg.sv -----
package hcbp_pkg;

    // Width of one packed output byte
    localparam int BYTE_W = 8;

    // Width of the right-aligned code word held in the table
    localparam int CODE_W = 32;

    // Width of the pending-bit accumulator (at most seven bits wait)
    localparam int PEND_W = 7;
    localparam int PCNT_W = 3;

    // Input beat operation codes
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

endpackage

// ----- design/hcbp_ram.sv -----
module hcbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/huffman_code_bit_packer.sv -----
// Table-driven Huffman encoder with an MSB-first bit packer.
// Input channel (in_valid / in_stall) carries one beat per operation:
//   load   - writes code_bits / code_length for table entry 'symbol';
//   encode - looks up 'symbol', appends its code, emits completed bytes;
//   flush  - zero-pads the pending bits and emits the final byte if any bits pend.
// Output channel (out_valid / out_stall) carries one packed byte per beat,
// first code bit in bit 7; 'last' marks the final byte caused by one input beat.
// An accepted encode or flush passes the table read register, then the packing
// register; it waits in stage 1 while the output register is not free.
// Throughput: one input beat per cycle while each beat yields at most one byte
// and the receiver does not stall; a beat that yields K bytes, up to
// (7 + MAX_CODE_LEN) / 8, holds the output register until all leave, one byte per unstalled cycle.
// A stalled receiver freezes the output byte; the input stalls, loads included,
// once the beat waiting behind the output register cannot move on.
// Reset clears the pending bits and the output register; the code table is not
// cleared, so every symbol must be loaded before it is encoded.
module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  symbol,
    input  logic [31:0] code_bits,
    input  logic [5:0]  code_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  packed_byte,
    output logic        last
);

    localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
    localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int ACC_W   = PEND_W + MAX_CODE_LEN;
    localparam int TOT_W   = $clog2(ACC_W + 1);
    localparam int NB      = (PEND_W + MAX_CODE_LEN) / BYTE_W;
    localparam int GRP_W   = NB * BYTE_W;
    localparam int CNT_W   = $clog2(NB + 1);

    op_t                op;
    logic               sym_ok;
    logic               in_accept;
    logic               wr_en;
    logic               rd_en;
    logic [LEN_W-1:0]   sat_len;
    logic [CODE_W-1:0]  code_mask;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_flush_reg;
    logic               s1_flush_next;
    logic               s1_fire;

    logic [PEND_W-1:0]  pend_bits_reg;
    logic [PEND_W-1:0]  pend_bits_next;
    logic [PCNT_W-1:0]  pend_count_reg;
    logic [PCNT_W-1:0]  pend_count_next;

    logic [GRP_W-1:0]   grp_bits_reg;
    logic [GRP_W-1:0]   grp_bits_next;
    logic [CNT_W-1:0]   grp_count_reg;
    logic [CNT_W-1:0]   grp_count_next;
    logic               grp_free;
    logic               pop;

    logic [LEN_W-1:0]   enc_len;
    logic [ACC_W-1:0]   enc_acc;
    logic [TOT_W-1:0]   enc_total;
    logic [ACC_W-1:0]   enc_left;
    logic [BYTE_W-1:0]  rem_mask;
    logic [BYTE_W-1:0]  flush_byte;

    // Input decode
    assign op        = op_t'(operation);
    assign sym_ok    = ({1'b0, symbol} < 9'(SYMBOL_COUNT));
    assign in_stall  = s1_valid_reg && !grp_free;
    assign in_accept = in_valid && !in_stall;
    assign wr_en     = in_accept && (op == OP_LOAD) && sym_ok;
    assign rd_en     = in_accept && (op == OP_ENCODE) && sym_ok;

    // Saturate length and drop code bits above it before storing
    always_comb
    begin
        if ({1'b0, code_length} > 7'(MAX_CODE_LEN))
        begin
            sat_len = LEN_W'(MAX_CODE_LEN);
        end
        else
        begin
            sat_len = LEN_W'(code_length);
        end
        for (int i = 0; i < CODE_W; i++)
        begin
            code_mask[i] = (7'(i) < 7'(sat_len));
        end
    end

    assign wr_entry = {sat_len, code_bits & code_mask};

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (symbol[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (symbol[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    // Output register handshake
    assign out_valid   = (grp_count_reg != '0);
    assign pop         = out_valid && !out_stall;
    assign grp_free    = (grp_count_reg == '0) || ((grp_count_reg == CNT_W'(1)) && !out_stall);
    assign s1_fire     = s1_valid_reg && grp_free;
    assign packed_byte = grp_bits_reg[GRP_W-1 -: BYTE_W];
    assign last        = (grp_count_reg == CNT_W'(1));

    // Stage 1 tracking: encode or flush beats waiting for the packer
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_flush_next = s1_flush_reg;
        if (in_accept)
        begin
            s1_valid_next = ((op == OP_ENCODE) && sym_ok) || (op == OP_FLUSH);
            s1_flush_next = (op == OP_FLUSH);
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Append the code to the pending bits and left-align completed bytes
    always_comb
    begin
        enc_len    = rd_entry[ENTRY_W-1 -: LEN_W];
        enc_acc    = (ACC_W'(pend_bits_reg) << enc_len)
                     | ACC_W'(rd_entry[CODE_W-1:0]);
        enc_total  = TOT_W'(pend_count_reg) + TOT_W'(enc_len);
        enc_left   = enc_acc << (TOT_W'(ACC_W) - enc_total);
        rem_mask   = (BYTE_W'(1) << enc_total[2:0]) - BYTE_W'(1);
        flush_byte = BYTE_W'({1'b0, pend_bits_reg} << (4'd8 - {1'b0, pend_count_reg}));
    end

    // Packer state and output group update
    always_comb
    begin
        pend_bits_next  = pend_bits_reg;
        pend_count_next = pend_count_reg;
        grp_bits_next   = grp_bits_reg;
        grp_count_next  = grp_count_reg;
        if (s1_fire)
        begin
            if (s1_flush_reg)
            begin
                grp_bits_next = '0;
                grp_bits_next[GRP_W-1 -: BYTE_W] = flush_byte;
                grp_count_next  = (pend_count_reg != '0) ? CNT_W'(1) : '0;
                pend_bits_next  = '0;
                pend_count_next = '0;
            end
            else
            begin
                grp_bits_next   = enc_left[ACC_W-1 -: GRP_W];
                grp_count_next  = CNT_W'(enc_total >> 3);
                pend_bits_next  = enc_acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
                pend_count_next = enc_total[2:0];
            end
        end
        else if (pop)
        begin
            grp_bits_next  = grp_bits_reg << BYTE_W;
            grp_count_next = grp_count_reg - CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            pend_bits_reg  <= '0;
            pend_count_reg <= '0;
            grp_count_reg  <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            pend_bits_reg  <= pend_bits_next;
            pend_count_reg <= pend_count_next;
            grp_count_reg  <= grp_count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_flush_reg <= s1_flush_next;
        grp_bits_reg <= grp_bits_next;
    end

endmodule

// ----- dv/huffman_code_bit_packer_tb.sv -----
module huffman_code_bit_packer_tb
    import hcbp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int RAND_BEATS   = 400;
    localparam int DIR_ROWS     = 24;

    // operation code that the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one code table entry as the block holds it
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [5:0]        len;
    } code_entry_t;

    // bytes caused by one input beat, first byte in [31:24]
    typedef struct packed {
        logic [2:0]  n;
        logic [31:0] bytes;
    } emit_t;

    // one output beat still to come
    typedef struct packed {
        logic [BYTE_W-1:0] pbyte;
        logic              lst;
    } out_beat_t;

    // one row of the directed stimulus; typed rows carry their own bytes
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [31:0] bits;
        logic [5:0]  len;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] bytes;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  packed_byte;
    logic        last;

    // packer state as predicted
    code_entry_t code_tab [SYMBOL_COUNT];
    logic [PEND_W-1:0] pend_bits = '0;
    logic [PCNT_W-1:0] pend_cnt  = '0;

    bit          loaded [SYMBOL_COUNT];
    logic [7:0]  loaded_syms [$];
    out_beat_t   expected_bytes [$];
    row_t        dir_tab [DIR_ROWS];
    int          errors = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_cyc = 0;

    huffman_code_bit_packer #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .symbol     (symbol),
        .code_bits  (code_bits),
        .code_length(code_length),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .packed_byte(packed_byte),
        .last       (last)
    );

    always #2 clk = ~clk;

    // predict the bytes of one beat and advance the packer state
    function automatic emit_t pack_beat(input logic [1:0] op, input logic [7:0] sym,
                                        input logic [31:0] bits, input logic [5:0] len);
        emit_t       r;
        logic [63:0] acc;
        logic [63:0] sh;
        logic [31:0] code;
        logic [7:0]  tail;
        int          l;
        int          total;
        r = '0;
        case (op)
            OP_LOAD:
            begin
                l = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(len);
                code_tab[sym].bits = bits;
                code_tab[sym].len  = l[5:0];
            end
            OP_ENCODE:
            begin
                l = code_tab[sym].len;
                if (l > MAX_CODE_LEN)
                    l = MAX_CODE_LEN;
                code = code_tab[sym].bits;
                if (l < 32)
                    code = code & ((32'd1 << l) - 32'd1);
                acc   = ({57'd0, pend_bits} << l) | {32'd0, code};
                total = int'(pend_cnt) + l;
                // every completed byte leaves, oldest bits first
                while (total >= 8)
                begin
                    total = total - 8;
                    sh = acc >> total;
                    r.bytes[31 - 8 * r.n -: 8] = sh[7:0];
                    r.n = r.n + 3'd1;
                end
                sh        = acc & ((64'd1 << total) - 64'd1);
                pend_bits = sh[PEND_W-1:0];
                pend_cnt  = total[PCNT_W-1:0];
            end
            OP_FLUSH:
            begin
                if (pend_cnt != 0)
                begin
                    tail = {1'b0, pend_bits} << (8 - int'(pend_cnt));
                    r.n = 3'd1;
                    r.bytes[31:24] = tail;
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // present one beat, wait for it to be taken, then queue its bytes
    task automatic drive_beat(input logic [1:0] op, input logic [7:0] sym,
                              input logic [31:0] bits, input logic [5:0] len,
                              input logic typed, input logic [2:0] typed_n,
                              input logic [31:0] typed_bytes);
        emit_t got;
        int    gap;
        int    k;
        // sender bursts with random gaps between them
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left  = burst_left - 1;
        in_valid    <= 1'b1;
        operation   <= op;
        symbol      <= sym;
        code_bits   <= bits;
        code_length <= len;
        do
            @(posedge clk);
        while (in_stall);
        got = pack_beat(op, sym, bits, len);
        if (typed)
        begin
            got.n     = typed_n;
            got.bytes = typed_bytes;
        end
        for (k = 0; k < got.n; k++)
            expected_bytes.push_back('{got.bytes[31 - 8 * k -: 8], k == got.n - 1});
        if (op == OP_LOAD && !loaded[sym])
        begin
            loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // hold the sender off until every queued byte has come out
    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
    endtask

    // receiver stall pattern, switching mode at random intervals
    always @(posedge clk)
    begin
        if (stall_cyc == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_cyc  = $urandom_range(20, 120);
        end
        stall_cyc = stall_cyc - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            2:       out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= (stall_cyc % 6 < 2);
        endcase
    end

    // compare each output beat with the oldest queued byte
    always @(posedge clk)
    begin : check_out
        out_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected beat: packed_byte %h last %b", packed_byte, last);
                errors++;
            end
            else
            begin
                e = expected_bytes.pop_front();
                if (packed_byte !== e.pbyte)
                begin
                    $error("packed_byte: expected %h, got %h", e.pbyte, packed_byte);
                    errors++;
                end
                if (last !== e.lst)
                begin
                    $error("last: expected %b, got %b", e.lst, last);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int          i;
        int          placed;
        int          pick;
        logic [1:0]  op;
        logic [7:0]  sym;
        logic [31:0] bits;
        logic [5:0]  len;

        in_valid    = 1'b0;
        operation   = OP_LOAD;
        symbol      = '0;
        code_bits   = '0;
        code_length = '0;
        rst_n       = 1'b0;

        // op, symbol, code bits, length, typed, byte count, expected bytes
        dir_tab = '{
            '{OP_LOAD,   8'h00, 32'h0000_00A5, 6'd8,  1'b1, 3'd0, 32'h0},
            '{OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0},
            '{OP_LOAD,   8'h01, 32'h0000_0005, 6'd3,  1'b1, 3'd0, 32'h0},
            // length above the maximum saturates
            '{OP_LOAD,   8'h02, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0},
            // zero-length code
            '{OP_LOAD,   8'h03, 32'hDEAD_BEEF, 6'd0,  1'b1, 3'd0, 32'h0},
            '{OP_LOAD,   8'h04, 32'hFFFF_FFFE, 6'd1,  1'b1, 3'd0, 32'h0},
            // flush with nothing pending
            '{OP_FLUSH,  8'h00, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0},
            '{OP_ENCODE, 8'h00, 32'h0,         6'd0,  1'b1, 3'd1, 32'hA500_0000},
            '{OP_ENCODE, 8'hFF, 32'h0,         6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF},
            '{OP_ENCODE, 8'h03, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0},
            '{OP_ENCODE, 8'h01, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0},
            '{OP_FLUSH,  8'h00, 32'h0,         6'd0,  1'b1, 3'd1, 32'hA000_0000},
            '{OP_UNUSED, 8'h7F, 32'h1234_5678, 6'd21, 1'b1, 3'd0, 32'h0},
            '{OP_ENCODE, 8'h01, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
            '{OP_ENCODE, 8'h02, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
            '{OP_ENCODE, 8'h04, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
            '{OP_LOAD,   8'h05, 32'h0000_0000, 6'd32, 1'b1, 3'd0, 32'h0},
            '{OP_ENCODE, 8'h05, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
            '{OP_LOAD,   8'h06, 32'h1234_5678, 6'd40, 1'b1, 3'd0, 32'h0},
            '{OP_ENCODE, 8'h06, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
            '{OP_LOAD,   8'h00, 32'h0000_007F, 6'd7,  1'b1, 3'd0, 32'h0},
            '{OP_ENCODE, 8'h00, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
            '{OP_FLUSH,  8'h00, 32'h0,         6'd0,  1'b0, 3'd0, 32'h0},
            '{OP_FLUSH,  8'h00, 32'h0,         6'd0,  1'b1, 3'd0, 32'h0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        for (i = 0; i < DIR_ROWS; i++)
            drive_beat(dir_tab[i].op, dir_tab[i].sym, dir_tab[i].bits, dir_tab[i].len,
                       dir_tab[i].typed, dir_tab[i].n, dir_tab[i].bytes);
        wait_drained();

        // random part: mostly encodes of loaded symbols, some loads, flushes and unused operations
        placed = 0;
        i = 0;
        while (placed < RAND_BEATS)
        begin
            if (i == RAND_BEATS / 2)
                wait_drained();
            i++;
            pick = $urandom_range(0, 99);
            bits = $urandom;
            len  = $urandom_range(0, 63);
            sym  = $urandom_range(0, 255);
            if (pick < 12)
            begin
                op = OP_LOAD;
                if ($urandom_range(0, 4) != 0)
                    len = $urandom_range(1, 12);
            end
            else if (pick < 82)
            begin
                op  = OP_ENCODE;
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end
            else if (pick < 94)
                op = OP_FLUSH;
            else
                op = OP_UNUSED;
            drive_beat(op, sym, bits, len, 1'b0, 3'd0, 32'h0);
            if (op != OP_UNUSED)
                placed++;
        end

        // let the last bytes drain, then a short tail
        wait_drained();
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
design/hcbp_pkg.sv
design/hcbp_ram.sv
design/huffman_code_bit_packer.sv
dv/huffman_code_bit_packer_tb.sv
